// File: rtl/qsa_pkg.sv
// ============================================================================
// qsa_pkg
// shared constants, operation codes and the divider cell word type
// ============================================================================
package qsa_pkg;

    localparam int DATA_W    = 16;
    localparam int KIND_W    = 3;
    localparam int FRAC_BITS = 15;

    // dividend magnitude shifted up by the fraction bits
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    // one quotient bit per cell
    localparam int DIV_STEPS = NUM_W;

    localparam logic signed [DATA_W-1:0] Q15_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] Q15_MIN = 16'sh8000;
    localparam int                       ROUND_HALF = 1 << 14;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEG = 3'd4;

    // word handed from one divider cell to the next
    typedef struct packed {
        logic                     valid;
        logic                     is_div;
        logic                     neg;
        logic signed [DATA_W-1:0] res;
        logic [DATA_W-1:0]        rem;
        logic [NUM_W-1:0]         num;
        logic [NUM_W-1:0]         quo;
        logic [DATA_W-1:0]        den;
    } cell_t;

endpackage

// File: rtl/qsa_if.sv
// ============================================================================
// qsa_if
// valid/ready channels for operation words and result words
// ============================================================================
interface qsa_cmd_if;
    logic                                    valid;
    logic                                    ready;
    logic [qsa_pkg::KIND_W-1:0]              kind;
    logic signed [qsa_pkg::DATA_W-1:0]       operand_a;
    logic signed [qsa_pkg::DATA_W-1:0]       operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    output ready);
endinterface

interface qsa_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [qsa_pkg::DATA_W-1:0]       result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// File: rtl/qsa_front.sv
// ============================================================================
// qsa_front
// operand stage: add, subtract, negate, product and divider setup
// ============================================================================
module qsa_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [qsa_pkg::KIND_W-1:0]        kind,
    input  logic signed [qsa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [qsa_pkg::DATA_W-1:0] operand_b,
    output qsa_pkg::cell_t                    head
);
    import qsa_pkg::*;

    logic                       valid_reg;
    logic [KIND_W-1:0]          kind_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0]   simp_reg;
    logic                       is_div_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [DATA_W-1:0]          den_reg;

    logic signed [DATA_W-1:0]   simp_next;
    logic                       is_div_next;
    logic signed [DATA_W:0]     sum;
    logic signed [DATA_W:0]     diff;
    logic signed [DATA_W:0]     negv;
    logic [DATA_W-1:0]          mag_a;
    logic [DATA_W-1:0]          mag_b;
    logic signed [2*DATA_W:0]   rnd;
    logic signed [DATA_W+1:0]   shf;
    logic signed [DATA_W-1:0]   mul_res;

    // clamp a one-bit-grown value to the q15 range
    function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = v[DATA_W] ? Q15_MIN : Q15_MAX;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    assign sum   = {operand_a[DATA_W-1], operand_a} + {operand_b[DATA_W-1], operand_b};
    assign diff  = {operand_a[DATA_W-1], operand_a} - {operand_b[DATA_W-1], operand_b};
    assign negv  = (DATA_W+1)'(0) - {operand_a[DATA_W-1], operand_a};
    assign mag_a = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a);
    assign mag_b = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);

    always_comb
    begin
        simp_next   = '0;
        is_div_next = 1'b0;
        unique case (kind)
            KIND_ADD: simp_next = sat17(sum);
            KIND_SUB: simp_next = sat17(diff);
            KIND_NEG: simp_next = sat17(negv);
            KIND_DIV:
            begin
                if (operand_b == '0)
                    simp_next = operand_a[DATA_W-1] ? Q15_MIN : Q15_MAX;
                else
                    is_div_next = 1'b1;
            end
            default: simp_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg   <= kind;
            prod_reg   <= operand_a * operand_b;
            simp_reg   <= simp_next;
            is_div_reg <= is_div_next;
            neg_reg    <= operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
            num_reg    <= {mag_a, {FRAC_BITS{1'b0}}};
            den_reg    <= mag_b;
        end
    end

    // round half up, arithmetic shift, clamp
    assign rnd = {prod_reg[2*DATA_W-1], prod_reg} + (2*DATA_W+1)'(ROUND_HALF);
    assign shf = rnd[2*DATA_W:FRAC_BITS];

    always_comb
    begin
        if (shf > (DATA_W+2)'(Q15_MAX))
            mul_res = Q15_MAX;
        else if (shf < (DATA_W+2)'(Q15_MIN))
            mul_res = Q15_MIN;
        else
            mul_res = shf[DATA_W-1:0];
    end

    always_comb
    begin
        head        = '0;
        head.valid  = valid_reg;
        head.is_div = is_div_reg;
        head.neg    = neg_reg;
        head.res    = (kind_reg == KIND_MUL) ? mul_res : simp_reg;
        head.rem    = '0;
        head.num    = num_reg;
        head.quo    = '0;
        head.den    = den_reg;
    end

endmodule

// File: rtl/qsa_div_cell.sv
// ============================================================================
// qsa_div_cell
// one restoring division step: one quotient bit per cell
// ============================================================================
module qsa_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  qsa_pkg::cell_t prev,
    output qsa_pkg::cell_t curr
);
    import qsa_pkg::*;

    cell_t           curr_reg;
    cell_t           curr_next;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] sub;
    logic            ge;

    assign trial = {prev.rem, prev.num[NUM_W-1]};
    assign sub   = trial - {1'b0, prev.den};
    assign ge    = trial >= {1'b0, prev.den};

    always_comb
    begin
        curr_next     = prev;
        curr_next.rem = ge ? sub[DATA_W-1:0] : trial[DATA_W-1:0];
        curr_next.num = {prev.num[NUM_W-2:0], 1'b0};
        curr_next.quo = {prev.quo[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            curr_reg <= '0;
        else if (en)
            curr_reg <= curr_next;
    end

    assign curr = curr_reg;

endmodule

// File: rtl/q15_saturating_alu.sv
// ============================================================================
// q15_saturating_alu
// saturating q15 fixed-point alu: add, subtract, multiply, divide, negate
// ============================================================================
// Takes one operation word per clock while the pipeline is not held, and
// returns one result word per operation, in order. The depth is set
// by the divider: an operand stage (sums, negate, 16x16 product), then a row
// of 31 restoring division cells that each settle one quotient bit of
// (|a| << 15) / |b|, then the output register that applies sign and clamping.
// Every operation rides the same pipeline, so words of all kinds follow each
// other back to back with no gaps. The whole pipeline holds while a result
// waits untaken in the output register; cmd.ready stays high whenever the
// output register is empty or being read. Division by zero gives +max for a
// dividend of zero or more and min otherwise; unused kind codes give zero.
module q15_saturating_alu (
    input  logic       clk,
    input  logic       rst_n,
    qsa_cmd_if.sink    cmd,
    qsa_rsp_if.source  rsp
);
    import qsa_pkg::*;

    // pipeline advance: output empty or being drained
    logic                     en;
    cell_t                    link [0:DIV_STEPS];
    cell_t                    tail;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_result_reg;
    logic signed [DATA_W-1:0] out_result_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign cmd.ready = en;

    // operand stage
    qsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cmd.valid),
        .kind      (cmd.kind),
        .operand_a (cmd.operand_a),
        .operand_b (cmd.operand_b),
        .head      (link[0])
    );

    // division cells, one quotient bit each, msb first
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        qsa_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (link[i]),
            .curr  (link[i+1])
        );
    end

    assign tail = link[DIV_STEPS];

    // quotient sign and clamp; other kinds carry their result through the row
    always_comb
    begin
        if (!tail.is_div)
            out_result_next = tail.res;
        else if (tail.neg)
        begin
            // magnitude 32768 maps exactly onto the minimum
            if (tail.quo > NUM_W'(-int'(Q15_MIN)))
                out_result_next = Q15_MIN;
            else
                out_result_next = DATA_W'(-tail.quo[DATA_W-1:0]);
        end
        else
        begin
            if (tail.quo > NUM_W'(Q15_MAX))
                out_result_next = Q15_MAX;
            else
                out_result_next = tail.quo[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_result_reg <= out_result_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;

endmodule

// File: dv/q15_saturating_alu_test.sv
`timescale 1ns / 1ps
// ============================================================================
// q15_saturating_alu_test
// self-checking bench for the saturating q15 alu
// ============================================================================
// A short directed list covers the saturation corners of every operation,
// the divide-by-zero rule, the rounding of multiply and the unused kind codes.
// About eleven hundred random words follow. Both ends of the pipe idle and
// stall at random, with calm stretches where the pipe runs at full rate. A
// scoreboard predicts each accepted word and checks the results in order.
module q15_saturating_alu_test;
    import qsa_pkg::*;

    // kind codes the alu does not define; they must give zero
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam int PIPE_DEPTH   = 33;
    localparam int RANDOM_WORDS = 1100;
    localparam int MAX_WAIT     = 17;
    localparam int REPORT_LINES = 40;

    typedef logic signed [DATA_W-1:0] q15_t;
    typedef logic [KIND_W-1:0]        kind_t;

    // one accepted operation and the result it must produce
    typedef struct {
        kind_t kind;
        q15_t  a;
        q15_t  b;
        q15_t  value;
    } alu_op_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts results of accepted words and checks them in order
    // ------------------------------------------------------------------------
    class alu_scoreboard;
        alu_op_t pending_results[$];
        int      mismatches;
        int      checked;

        function q15_t saturate(longint v);
            if (v > Q15_MAX)
                return Q15_MAX;
            if (v < Q15_MIN)
                return Q15_MIN;
            return q15_t'(v);
        endfunction

        function q15_t saturated_result(kind_t kind, q15_t a, q15_t b);
            longint wa;
            longint wb;
            wa = a;
            wb = b;
            case (kind)
                KIND_ADD: return saturate(wa + wb);
                KIND_SUB: return saturate(wa - wb);
                // full product, round half up, arithmetic shift
                KIND_MUL: return saturate((wa * wb + ROUND_HALF) >>> FRAC_BITS);
                KIND_DIV:
                begin
                    if (wb == 0)
                        return (wa >= 0) ? Q15_MAX : Q15_MIN;
                    // sv division truncates toward zero
                    return saturate((wa <<< FRAC_BITS) / wb);
                end
                KIND_NEG: return saturate(-wa);
                default:  return '0;
            endcase
        endfunction

        function void note_op(kind_t kind, q15_t a, q15_t b);
            alu_op_t op;
            op.kind  = kind;
            op.a     = a;
            op.b     = b;
            op.value = saturated_result(kind, a, b);
            pending_results.push_back(op);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(q15_t got);
            alu_op_t op;
            checked++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d with no operation outstanding", got));
                return;
            end
            op = pending_results.pop_front();
            if (got !== op.value)
                report($sformatf("kind %0d a %0d b %0d: result %0d, want %0d",
                                 op.kind, op.a, op.b, got, op.value));
        endtask
    endclass

    logic clk;
    logic rst_n;

    qsa_cmd_if cmd ();
    qsa_rsp_if rsp ();

    alu_scoreboard board;

    // remaining words of a no-idle stretch on each side
    int send_calm;
    int take_calm;
    int kind_seen [8];

    q15_saturating_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("timeout: %0d results still outstanding", board.pending_results.size());
        $display("simulation failed");
        $finish;
    end

    // idle cycles before the next word; now and then a calm stretch of zeros
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm_left = $urandom_range(20, 80);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // operands lean toward the corners, small values and powers of two
    function automatic q15_t draw_operand();
        q15_t v;
        case ($urandom_range(0, 7))
            0:       v = Q15_MIN;
            1:       v = Q15_MAX;
            2:       v = q15_t'(int'($urandom_range(0, 32)) - 16);
            3:
            begin
                v = q15_t'(1 << $urandom_range(0, DATA_W - 1));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = q15_t'($urandom);
        endcase
        return v;
    endfunction

    // drive one operation word, hold it until the alu takes it
    task automatic send_op(kind_t kind, q15_t a, q15_t b);
        int gap;
        gap = draw_wait(send_calm);
        repeat (gap)
        begin
            @(negedge clk);
            cmd.valid <= 1'b0;
        end
        @(negedge clk);
        cmd.valid     <= 1'b1;
        cmd.kind      <= kind;
        cmd.operand_a <= a;
        cmd.operand_b <= b;
        do
            @(posedge clk);
        while (!cmd.ready);
        board.note_op(kind, a, b);
        kind_seen[kind]++;
    endtask

    task automatic random_op();
        kind_t kind;
        q15_t  a;
        q15_t  b;
        int    mag;
        // a few words with the unused codes, the rest spread over real kinds
        if ($urandom_range(0, 99) < 6)
            kind = kind_t'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        else
            kind = kind_t'($urandom_range(KIND_ADD, KIND_NEG));
        a = draw_operand();
        b = draw_operand();
        if (kind == KIND_DIV)
        begin
            if ($urandom_range(0, 19) == 0)
                b = '0;
            else if ($urandom_range(0, 1))
            begin
                // keep |a| under |b| so most quotients land inside the range
                mag = (b < 0) ? -int'(b) : int'(b);
                if (mag != 0)
                begin
                    a = q15_t'($urandom_range(0, mag - 1));
                    if ($urandom_range(0, 1))
                        a = -a;
                end
            end
        end
        send_op(kind, a, b);
    endtask

    // result side: random stalls, every taken word goes to the scoreboard
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait(take_calm);
            repeat (gap)
            begin
                @(negedge clk);
                rsp.ready <= 1'b0;
            end
            @(negedge clk);
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            board.check_result(rsp.result);
        end
    end

    initial
    begin
        board         = new();
        send_calm     = 0;
        take_calm     = 0;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.kind      = KIND_ADD;
        cmd.operand_a = '0;
        cmd.operand_b = '0;
        rsp.ready     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // add and subtract clamping at both ends
        send_op(KIND_ADD, Q15_MAX, Q15_MAX);
        send_op(KIND_ADD, Q15_MIN, Q15_MIN);
        send_op(KIND_ADD, -1, 1);
        send_op(KIND_SUB, Q15_MIN, 1);
        send_op(KIND_SUB, Q15_MAX, -1);
        send_op(KIND_SUB, 0, Q15_MIN);
        // minimum times minimum overflows after rounding
        send_op(KIND_MUL, Q15_MIN, Q15_MIN);
        send_op(KIND_MUL, Q15_MAX, Q15_MAX);
        send_op(KIND_MUL, Q15_MIN, Q15_MAX);
        // exact halves: rounding goes up, also for negative products
        send_op(KIND_MUL, 1, 16384);
        send_op(KIND_MUL, -1, 16384);
        // divide by zero picks the bound from the dividend sign, zero is positive
        send_op(KIND_DIV, 0, 0);
        send_op(KIND_DIV, 5, 0);
        send_op(KIND_DIV, -1, 0);
        send_op(KIND_DIV, Q15_MIN, -1);
        send_op(KIND_DIV, Q15_MIN, Q15_MIN);
        send_op(KIND_DIV, Q15_MAX, Q15_MIN);
        send_op(KIND_DIV, 1, Q15_MAX);
        // truncation toward zero on a negative quotient
        send_op(KIND_DIV, -16384, Q15_MAX);
        // negate of minimum saturates; second operand is ignored
        send_op(KIND_NEG, Q15_MIN, Q15_MAX);
        send_op(KIND_NEG, Q15_MAX, Q15_MIN);
        send_op(KIND_NEG, 0, -1);
        // unused codes give zero whatever the operands
        send_op(KIND_SPARE_FIRST, Q15_MAX, Q15_MAX);
        send_op(kind_t'(KIND_SPARE_FIRST + 1), Q15_MIN, -1);
        send_op(KIND_SPARE_LAST, -1, Q15_MIN);

        repeat (RANDOM_WORDS) random_op();
        @(negedge clk);
        cmd.valid <= 1'b0;

        // drain, then give the pipe time to show any stray result
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("covered add %0d, sub %0d, mul %0d, div %0d, neg %0d, unused codes %0d",
                 kind_seen[KIND_ADD], kind_seen[KIND_SUB], kind_seen[KIND_MUL],
                 kind_seen[KIND_DIV], kind_seen[KIND_NEG],
                 kind_seen[KIND_SPARE_FIRST] + kind_seen[KIND_SPARE_FIRST + 1]
                     + kind_seen[KIND_SPARE_LAST]);
        $display("%0d result words checked under random idling, %0d mismatches",
                 board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/qsa_pkg.sv
rtl/qsa_if.sv
rtl/qsa_front.sv
rtl/qsa_div_cell.sv
rtl/q15_saturating_alu.sv
dv/q15_saturating_alu_test.sv
